// ===== hw/rtl/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes for the fit-policy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  localparam int unsigned MaxBlocksDef   = 64;
  localparam int unsigned HeapBytesDef   = 65536;
  localparam int unsigned HeaderBytesDef = 24;

  localparam int unsigned OffsetLimit = 65535;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] request_bytes;
    logic [15:0] free_offset;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data_offset;
    logic [16:0] granted_size;
    logic        reused;
  } rsp_t;

  // one table entry
  typedef struct packed {
    logic        used;
    logic [15:0] off;
    logic [16:0] size;
  } blk_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fit_policy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Heap block allocator with first, next and best fit over a block table.
// ----------------------------------------------------------------------------
//  channel  | ports                      | handshake
//  ---------+----------------------------+------------------------------------
//  command  | start, busy, cmd_i         | taken when start && !busy
//  result   | done_o, rsp_o              | one-cycle strobe, never stalled
//  config   | cfg_we_i, cfg_wdata_i      | fit_mode written when cfg_we_i
//
//  Allocate and free scan the table one entry a cycle through the memory read
//  port. A split then shifts any entries above the picked one up one entry, one
//  entry a cycle. Clear and unused ops finish from idle without a scan. Reset
//  clears count, heap top and next-fit start; table contents are not reset. The
//  result cannot be stalled.
`default_nettype none

module fit_policy_block_allocator_unit
  import fpba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = MaxBlocksDef,
  parameter int unsigned HEAP_BYTES   = HeapBytesDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start,
  output logic       busy,
  input  cmd_t       cmd_i,
  output logic       done_o,
  output rsp_t       rsp_o,
  input  wire        cfg_we_i,
  input  wire  [1:0] cfg_wdata_i
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_BLOCKS);
  localparam logic [17:0]   HdrW   = 18'(HEADER_BYTES);
  localparam logic [17:0]   HeapW  = 18'(HEAP_BYTES);
  localparam logic [17:0]   OffLim = 18'(OffsetLimit);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WR_REM, S_WR_PICK
  } state_e;

  blk_t mem [MAX_BLOCKS];
  blk_t rdata_q;

  state_e        state_q, state_d;
  logic [1:0]    mode_q;
  logic [CW-1:0] count_q, count_d;
  logic [16:0]   top_q, top_d;
  logic          nfs_v_q, nfs_v_d;
  logic [IW-1:0] nfs_q, nfs_d;
  logic [1:0]    op_q, op_d;
  logic [16:0]   req_q, req_d;
  logic [15:0]   foff_q, foff_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          rv_q, rv_d;
  logic [IW-1:0] ri_q, ri_d;
  logic          found_q, found_d;
  logic [IW-1:0] pick_q, pick_d;
  blk_t          pdat_q, pdat_d;
  logic [16:0]   bleft_q, bleft_d;
  logic [IW-1:0] sh_q, sh_d;
  blk_t          wpick_q, wpick_d;
  logic [IW-1:0] wpidx_q, wpidx_d;
  blk_t          rem_q, rem_d;
  logic          done_q, done_d;
  rsp_t          rsp_q, rsp_d;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  blk_t          wdata;

  logic          fit, hit;
  logic [16:0]   left;
  logic [17:0]   grow_end, grow_off;
  logic          split;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign fit  = !rdata_q.used && (rdata_q.size >= req_q);
  assign left = rdata_q.size - req_q;
  assign hit  = rv_q && ((op_q == OP_FREE) ? (rdata_q.off == foff_q)
                                           : (fit && mode_q != FIT_BEST));
  assign grow_off = {1'b0, top_q} + HdrW;
  assign grow_end = grow_off + {1'b0, req_q};
  assign split    = (pdat_q.size > req_q) && (count_q < CntMax);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    top_d   = top_q;
    nfs_v_d = nfs_v_q;
    nfs_d   = nfs_q;
    op_d    = op_q;
    req_d   = req_q;
    foff_d  = foff_q;
    scan_d  = scan_q;
    rv_d    = 1'b0;
    ri_d    = ri_q;
    found_d = found_q;
    pick_d  = pick_q;
    pdat_d  = pdat_q;
    bleft_d = bleft_q;
    sh_d    = sh_q;
    wpick_d = wpick_q;
    wpidx_d = wpidx_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = wpidx_q;
    wdata   = wpick_q;
    raddr   = scan_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = cmd_i.op;
          req_d   = ({1'b0, cmd_i.request_bytes} + 17'd7) & ~17'd7;
          foff_d  = cmd_i.free_offset;
          found_d = 1'b0;
          rsp_d   = '0;
          scan_d  = (cmd_i.op == OP_ALLOC && mode_q == FIT_NEXT && nfs_v_q)
                    ? CW'(nfs_q) : '0;
          if (cmd_i.op == OP_ALLOC || cmd_i.op == OP_FREE) begin
            state_d = S_SCAN;
          end else begin
            if (cmd_i.op == OP_CLEAR) begin
              count_d = '0;
              top_d   = '0;
              nfs_v_d = 1'b0;
              nfs_d   = '0;
            end
            done_d = 1'b1;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          found_d = 1'b1;
          pick_d  = ri_q;
          pdat_d  = rdata_q;
        end else if (rv_q && fit && op_q == OP_ALLOC && mode_q == FIT_BEST &&
                     (!found_q || left < bleft_q)) begin
          found_d = 1'b1;
          pick_d  = ri_q;
          pdat_d  = rdata_q;
          bleft_d = left;
        end
        if (hit || scan_q >= count_q) begin
          state_d = S_DECIDE;
        end else begin
          rv_d   = 1'b1;
          ri_d   = scan_q[IW-1:0];
          scan_d = scan_q + 1'b1;
        end
      end

      S_DECIDE: begin
        if (op_q == OP_FREE) begin
          if (found_q) begin
            wpidx_d      = pick_q;
            wpick_d      = pdat_q;
            wpick_d.used = 1'b0;
            state_d      = S_WR_PICK;
          end else begin
            rsp_d.status = ST_NOMATCH;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (found_q) begin
          wpidx_d      = pick_q;
          wpick_d      = pdat_q;
          wpick_d.used = 1'b1;
          nfs_v_d      = 1'b1;
          nfs_d        = pick_q;
          rsp_d.data_offset  = pdat_q.off;
          rsp_d.granted_size = pdat_q.size;
          rsp_d.reused       = 1'b1;
          if (split) begin
            wpick_d.size       = req_q;
            rsp_d.granted_size = req_q;
            rem_d.used = 1'b0;
            rem_d.off  = pdat_q.off + req_q[15:0];
            rem_d.size = pdat_q.size - req_q;
            sh_d       = IW'(count_q - 1'b1);
            if (CW'(pick_q) + 1'b1 < count_q) begin
              state_d = S_SHIFT;
            end else begin
              state_d = S_WR_REM;
            end
          end else begin
            state_d = S_WR_PICK;
          end
        end else if (count_q >= CntMax || grow_end > HeapW || grow_off > OffLim) begin
          rsp_d.status = ST_NOSPACE;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          wpidx_d      = count_q[IW-1:0];
          wpick_d.used = 1'b1;
          wpick_d.off  = grow_off[15:0];
          wpick_d.size = req_q;
          count_d      = count_q + 1'b1;
          top_d        = grow_end[16:0];
          nfs_v_d      = 1'b1;
          nfs_d        = count_q[IW-1:0];
          rsp_d.data_offset  = grow_off[15:0];
          rsp_d.granted_size = req_q;
          state_d      = S_WR_PICK;
        end
      end

      S_SHIFT: begin
        // move tail up one entry, top down
        if (rv_q) begin
          we    = 1'b1;
          waddr = ri_q + 1'b1;
          wdata = rdata_q;
        end
        raddr = sh_q;
        if (sh_q > pick_q) begin
          rv_d = 1'b1;
          ri_d = sh_q;
          sh_d = sh_q - 1'b1;
        end else if (!rv_q) begin
          state_d = S_WR_REM;
        end
      end

      S_WR_REM: begin
        we      = 1'b1;
        waddr   = pick_q + 1'b1;
        wdata   = rem_q;
        count_d = count_q + 1'b1;
        state_d = S_WR_PICK;
      end

      S_WR_PICK: begin
        we      = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= FIT_FIRST;
      count_q <= '0;
      top_q   <= '0;
      nfs_v_q <= 1'b0;
      nfs_q   <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
      op_q    <= '0;
      req_q   <= '0;
      foff_q  <= '0;
      scan_q  <= '0;
      ri_q    <= '0;
      found_q <= 1'b0;
      pick_q  <= '0;
      pdat_q  <= '0;
      bleft_q <= '0;
      sh_q    <= '0;
      wpick_q <= '0;
      wpidx_q <= '0;
      rem_q   <= '0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      top_q   <= top_d;
      nfs_v_q <= nfs_v_d;
      nfs_q   <= nfs_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
      op_q    <= op_d;
      req_q   <= req_d;
      foff_q  <= foff_d;
      scan_q  <= scan_d;
      ri_q    <= ri_d;
      found_q <= found_d;
      pick_q  <= pick_d;
      pdat_q  <= pdat_d;
      bleft_q <= bleft_d;
      sh_q    <= sh_d;
      wpick_q <= wpick_d;
      wpidx_q <= wpidx_d;
      rem_q   <= rem_d;
      rsp_q   <= rsp_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fpba_checker.sv =====
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks for the block allocator, bound to the allocator unit.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_checker
  import fpba_pkg::*;
(
  input wire  clk_i,
  input wire  rst_ni,
  input wire  start,
  input wire  busy,
  input wire  done_o,
  input rsp_t rsp_o
);

  // an accepted item either finishes at once or keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted item neither busy nor done");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy ended without a result");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |->
      rsp_o.data_offset == '0 && rsp_o.granted_size == '0 && !rsp_o.reused)
    else $error("failed item carries data");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

`default_nettype wire
